FILE: hw/rtl/dead_reckoning_integrator_macros.svh
// assertion macros for the dead reckoning integrator
// depends on nothing; included by the modules that assert
`ifndef DEAD_RECKONING_INTEGRATOR_MACROS_SVH
`define DEAD_RECKONING_INTEGRATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock outside reset
`define DRI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define DRI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define DRI_ASSERT(lbl, clk, rstn, prop, msg)
`define DRI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/dri_pkg.sv
// shared types, constants and arithmetic helpers of the dead reckoning integrator
// depends on nothing
package dri_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_RUN = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
	localparam int CORDIC_CW = (CORDIC_RUN > 1) ? $clog2(CORDIC_RUN) : 1;

	localparam logic [1:0] ST_START = 2'd0;
	localparam logic [1:0] ST_SKIP  = 2'd1;
	localparam logic [1:0] ST_INTEG = 2'd2;

	localparam logic [19:0] US_PER_S = 20'd1000000;
	localparam int DIV_W = 52;
	localparam int DIV_BITS = 4;
	localparam int DIV_CYCLES = DIV_W / DIV_BITS;
	localparam int DIV_CW = $clog2(DIV_CYCLES);
	localparam int Q_W = 33;

	localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [32:0] DECAY_Q16 = 33'sd55706;
	localparam logic signed [32:0] DAMP_Q16 = 33'sd64881;
	localparam logic signed [31:0] SNAP_Q16 = 32'sd328;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic [15:0]        heading;
		logic [19:0]        elapsed_us;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic [1:0]         step_status;
		logic               new_point;
	} result_t;

	typedef struct packed {
		logic [15:0] pixels_per_meter;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] accel_threshold;
		logic [19:0] dt_limit_us;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic [15:0]        heading;
		logic [19:0]        dt;
	} op_t;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic [29:0] atan_turn32(input logic [4:0] i);
		case (i)
			5'd0:  return 30'd536870912;
			5'd1:  return 30'd316933406;
			5'd2:  return 30'd167458907;
			5'd3:  return 30'd85004756;
			5'd4:  return 30'd42667331;
			5'd5:  return 30'd21354465;
			5'd6:  return 30'd10679838;
			5'd7:  return 30'd5340245;
			5'd8:  return 30'd2670163;
			5'd9:  return 30'd1335087;
			5'd10: return 30'd667544;
			5'd11: return 30'd333772;
			5'd12: return 30'd166886;
			5'd13: return 30'd83443;
			5'd14: return 30'd41722;
			5'd15: return 30'd20861;
			5'd16: return 30'd10430;
			5'd17: return 30'd5215;
			5'd18: return 30'd2608;
			5'd19: return 30'd1304;
			5'd20: return 30'd652;
			5'd21: return 30'd326;
			5'd22: return 30'd163;
			5'd23: return 30'd81;
			default: return 30'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		if (v < -40'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// product shifted right, rounded toward zero
	function automatic logic signed [31:0] tz32(input logic signed [65:0] p, input int n);
		logic signed [65:0] s;
		logic signed [65:0] m;
		s = p >>> n;
		m = (66'sd1 <<< n) - 66'sd1;
		if (p[65] && ((p & m) != 66'sd0))
			s = s + 66'sd1;
		return s[31:0];
	endfunction

	function automatic logic [DIV_W-1:0] mag52(input logic signed [65:0] p);
		logic signed [65:0] a;
		a = p[65] ? -p : p;
		return a[DIV_W-1:0];
	endfunction

	function automatic logic signed [31:0] snap(input logic signed [31:0] v);
		return (v > -SNAP_Q16 && v < SNAP_Q16) ? 32'sd0 : v;
	endfunction

endpackage

FILE: hw/rtl/dri_front.sv
// front end: accepts samples, clamps elapsed time, classifies, queues ops
// depends on dri_pkg
module dri_front import dri_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  sample_t sample,
	input  cfg_t    cfg,
	output logic    op_valid,
	output op_t     op,
	input  logic    op_take
);

	logic       started_q;
	op_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic [19:0] dt_c;
	op_t        op_new;

	assign full = (cnt_q == 2'd2);
	assign accept = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign op = ent_q[rd_q];

	always_comb begin
		dt_c = (sample.elapsed_us > cfg.dt_limit_us) ? cfg.dt_limit_us : sample.elapsed_us;
		op_new.accel_x = sample.accel_x;
		op_new.accel_y = sample.accel_y;
		op_new.heading = sample.heading;
		op_new.dt = dt_c;
		if (!started_q)
			op_new.kind = ST_START;
		else if (dt_c == 20'd0)
			op_new.kind = ST_SKIP;
		else
			op_new.kind = ST_INTEG;
	end

	always_ff @(posedge clk) begin
		if (accept)
			ent_q[wr_q] <= op_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				started_q <= 1'b1;
				wr_q <= ~wr_q;
			end
			if (op_take)
				rd_q <= ~rd_q;
			case ({accept, op_take})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/dri_cordic.sv
// iterative cordic rotator, one stage per cycle
// depends on dri_pkg
module dri_cordic import dri_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic [15:0]        h,
	output logic               done,
	output logic signed [31:0] x,
	output logic signed [31:0] y
);

	logic                 busy_q;
	logic                 done_q;
	logic [CORDIC_CW-1:0] cnt_q;
	logic signed [31:0]   x_q;
	logic signed [31:0]   y_q;
	logic signed [32:0]   z_q;
	logic signed [31:0]   x0, y0;
	logic signed [16:0]   zh;
	logic signed [32:0]   at;
	logic signed [31:0]   xs, ys;

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;

	always_comb begin
		x0 = {{2{ax[15]}}, ax, 14'b0};
		y0 = {{2{ay[15]}}, ay, 14'b0};
		if (h >= 16'd16384 && h < 16'd49152) begin
			x0 = -x0;
			y0 = -y0;
			zh = signed'({1'b0, h}) - 17'sd32768;
		end else if (h >= 16'd49152) begin
			zh = signed'({1'b0, h}) - 17'sd65536;
		end else begin
			zh = signed'({1'b0, h});
		end
		at = signed'({3'b0, atan_turn32(5'(cnt_q))});
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= {zh, 16'b0};
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CORDIC_CW'(CORDIC_RUN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/dri_cdiv.sv
// two-lane divider by one million, four quotient bits per cycle
// depends on dri_pkg
module dri_cdiv import dri_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] nx,
	input  logic [DIV_W-1:0] ny,
	output logic             done,
	output logic [Q_W-1:0]   qx,
	output logic [Q_W-1:0]   qy
);

	logic [DIV_W-1:0]  n_q [2];
	logic [19:0]       r_q [2];
	logic [DIV_W-1:0]  n_d [2];
	logic [19:0]       r_d [2];
	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [20:0]       t;

	assign done = done_q;
	assign qx = n_q[0][Q_W-1:0];
	assign qy = n_q[1][Q_W-1:0];

	always_comb begin
		t = '0;
		for (int l = 0; l < 2; l++) begin
			n_d[l] = n_q[l];
			r_d[l] = r_q[l];
			for (int k = 0; k < DIV_BITS; k++) begin
				t = {r_d[l], n_d[l][DIV_W-1]};
				n_d[l] = {n_d[l][DIV_W-2:0], 1'b0};
				if (t >= {1'b0, US_PER_S}) begin
					t = t - {1'b0, US_PER_S};
					n_d[l][0] = 1'b1;
				end
				r_d[l] = t[19:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q[0] <= nx;
			n_q[1] <= ny;
			r_q[0] <= '0;
			r_q[1] <= '0;
		end else if (busy_q) begin
			n_q <= n_d;
			r_q <= r_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CW'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/dri_back.sv
// back end: sequencer with shared multiplier, navigation state and result queue
// depends on dri_pkg, dri_cordic, dri_cdiv and the assertion macros
`include "dead_reckoning_integrator_macros.svh"
module dri_back import dri_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    op_valid,
	input  op_t     op,
	output logic    op_take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ROT  = 5'd1;
	localparam logic [4:0] S_MGX  = 5'd2;
	localparam logic [4:0] S_MGY  = 5'd3;
	localparam logic [4:0] S_MSQX = 5'd4;
	localparam logic [4:0] S_MSQY = 5'd5;
	localparam logic [4:0] S_MTHR = 5'd6;
	localparam logic [4:0] S_CMP  = 5'd7;
	localparam logic [4:0] S_DECX = 5'd8;
	localparam logic [4:0] S_DECY = 5'd9;
	localparam logic [4:0] S_DECW = 5'd10;
	localparam logic [4:0] S_GDX  = 5'd11;
	localparam logic [4:0] S_GDY  = 5'd12;
	localparam logic [4:0] S_GDW  = 5'd13;
	localparam logic [4:0] S_GDIV = 5'd14;
	localparam logic [4:0] S_DMPX = 5'd15;
	localparam logic [4:0] S_DMPY = 5'd16;
	localparam logic [4:0] S_DMPW = 5'd17;
	localparam logic [4:0] S_VDX  = 5'd18;
	localparam logic [4:0] S_VDY  = 5'd19;
	localparam logic [4:0] S_VDW  = 5'd20;
	localparam logic [4:0] S_VDIV = 5'd21;
	localparam logic [4:0] S_PPX  = 5'd22;
	localparam logic [4:0] S_PPY  = 5'd23;
	localparam logic [4:0] S_PPW  = 5'd24;
	localparam logic [4:0] S_DONE = 5'd25;

	logic [4:0]         state_q;
	logic signed [31:0] vx_q, vy_q, pe_q, pn_q, lpx_q, lpy_q, px_q;
	logic signed [25:0] gx_q, gy_q;
	logic [51:0]        sq_q;
	logic [19:0]        dt_q;
	logic [1:0]         status_q;
	logic               newp_q;
	logic               sx_q, sy_q;
	logic [DIV_W-1:0]   dx_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_s1;

	logic               cor_start, cor_done;
	logic signed [31:0] cor_x, cor_y;
	logic               div_start, div_done;
	logic [Q_W-1:0]     div_qx, div_qy;
	logic signed [31:0] py_new;

	result_t            rq_q [2];
	logic               rq_wr_q, rq_rd_q;
	logic [1:0]         rq_cnt_q;
	logic               rq_push, rq_pop;
	result_t            res_new;

	function automatic logic signed [31:0] add_q(input logic signed [31:0] v,
			input logic [Q_W-1:0] q, input logic neg);
		logic signed [39:0] qs;
		qs = signed'({{(40 - Q_W){1'b0}}, q});
		return sat32(40'(v) + (neg ? -qs : qs));
	endfunction

	dri_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.ax     (op.accel_x),
		.ay     (op.accel_y),
		.h      (op.heading),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y)
	);

	dri_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.nx     (dx_q),
		.ny     (mag52(prod_s1)),
		.done   (div_done),
		.qx     (div_qx),
		.qy     (div_qy)
	);

	assign op_take = (state_q == S_IDLE) && op_valid && (rq_cnt_q != 2'd2);
	assign cor_start = op_take && (op.kind == ST_INTEG);
	assign div_start = (state_q == S_GDW) || (state_q == S_VDW);

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_MGX:  begin mul_a = 33'(cor_x); mul_b = INV_GAIN_Q30; end
			S_MGY:  begin mul_a = 33'(cor_y); mul_b = INV_GAIN_Q30; end
			S_MSQX: begin mul_a = 33'(gx_q); mul_b = 33'(gx_q); end
			S_MSQY: begin mul_a = 33'(gy_q); mul_b = 33'(gy_q); end
			S_MTHR: begin
				mul_a = signed'({17'b0, cfg.accel_threshold});
				mul_b = signed'({17'b0, cfg.accel_threshold});
			end
			S_DECX: begin mul_a = 33'(vx_q); mul_b = DECAY_Q16; end
			S_DECY: begin mul_a = 33'(vy_q); mul_b = DECAY_Q16; end
			S_GDX:  begin mul_a = 33'(gx_q); mul_b = signed'({13'b0, dt_q}); end
			S_GDY:  begin mul_a = 33'(gy_q); mul_b = signed'({13'b0, dt_q}); end
			S_DMPX: begin mul_a = 33'(vx_q); mul_b = DAMP_Q16; end
			S_DMPY: begin mul_a = 33'(vy_q); mul_b = DAMP_Q16; end
			S_VDX:  begin mul_a = 33'(vx_q); mul_b = signed'({13'b0, dt_q}); end
			S_VDY:  begin mul_a = 33'(vy_q); mul_b = signed'({13'b0, dt_q}); end
			S_PPX:  begin mul_a = 33'(pe_q); mul_b = signed'({17'b0, cfg.pixels_per_meter}); end
			S_PPY:  begin mul_a = 33'(pn_q); mul_b = signed'({17'b0, cfg.pixels_per_meter}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign py_new = sat32(signed'({24'b0, cfg.origin_y}) - 40'(tz32(prod_s1, 24)));

	// datapath captures
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dt_q <= op.dt;
				status_q <= op.kind;
			end
			S_MGY:  gx_q <= prod_s1[61:36];
			S_MSQX: gy_q <= prod_s1[61:36];
			S_MSQY: sq_q <= prod_s1[51:0];
			S_MTHR: sq_q <= sq_q + prod_s1[51:0];
			S_GDY, S_VDY: begin
				dx_q <= mag52(prod_s1);
				sx_q <= prod_s1[65];
			end
			S_GDW, S_VDW: sy_q <= prod_s1[65];
			S_PPY: px_q <= sat32(signed'({24'b0, cfg.origin_x}) + 40'(tz32(prod_s1, 16 + 8)));
			default: ;
		endcase
	end

	// sequencer and navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vx_q <= '0;
			vy_q <= '0;
			pe_q <= '0;
			pn_q <= '0;
			lpx_q <= '0;
			lpy_q <= '0;
			newp_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op_take) begin
						case (op.kind)
							ST_START: begin
								lpx_q <= signed'({16'b0, cfg.origin_x});
								lpy_q <= signed'({16'b0, cfg.origin_y});
								newp_q <= 1'b1;
								state_q <= S_DONE;
							end
							ST_INTEG: begin
								newp_q <= 1'b0;
								state_q <= S_ROT;
							end
							default: begin
								newp_q <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ROT:  if (cor_done) state_q <= S_MGX;
				S_MGX:  state_q <= S_MGY;
				S_MGY:  state_q <= S_MSQX;
				S_MSQX: state_q <= S_MSQY;
				S_MSQY: state_q <= S_MTHR;
				S_MTHR: state_q <= S_CMP;
				S_CMP:  state_q <= (sq_q < {prod_s1[35:0], 16'b0}) ? S_DECX : S_GDX;
				S_DECX: state_q <= S_DECY;
				S_DECY: begin
					vx_q <= tz32(prod_s1, 16);
					state_q <= S_DECW;
				end
				S_DECW: begin
					vy_q <= tz32(prod_s1, 16);
					state_q <= S_DMPX;
				end
				S_GDX:  state_q <= S_GDY;
				S_GDY:  state_q <= S_GDW;
				S_GDW:  state_q <= S_GDIV;
				S_GDIV: begin
					if (div_done) begin
						vx_q <= add_q(vx_q, div_qx, sx_q);
						vy_q <= add_q(vy_q, div_qy, sy_q);
						state_q <= S_DMPX;
					end
				end
				S_DMPX: state_q <= S_DMPY;
				S_DMPY: begin
					vx_q <= snap(tz32(prod_s1, 16));
					state_q <= S_DMPW;
				end
				S_DMPW: begin
					vy_q <= snap(tz32(prod_s1, 16));
					state_q <= S_VDX;
				end
				S_VDX:  state_q <= S_VDY;
				S_VDY:  state_q <= S_VDW;
				S_VDW:  state_q <= S_VDIV;
				S_VDIV: begin
					if (div_done) begin
						pe_q <= add_q(pe_q, div_qx, sx_q);
						pn_q <= add_q(pn_q, div_qy, sy_q);
						state_q <= S_PPX;
					end
				end
				S_PPX:  state_q <= S_PPY;
				S_PPY:  state_q <= S_PPW;
				S_PPW: begin
					newp_q <= (px_q != lpx_q) || (py_new != lpy_q);
					lpx_q <= px_q;
					lpy_q <= py_new;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result queue
	assign rq_push = (state_q == S_DONE);
	assign rq_pop = pop && !empty;
	assign empty = (rq_cnt_q == 2'd0);
	assign result = rq_q[rq_rd_q];

	always_comb begin
		res_new.pixel_x = lpx_q;
		res_new.pixel_y = lpy_q;
		res_new.position_x = pe_q;
		res_new.position_y = pn_q;
		res_new.step_status = status_q;
		res_new.new_point = newp_q;
	end

	always_ff @(posedge clk) begin
		if (rq_push)
			rq_q[rq_wr_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q <= 1'b0;
			rq_rd_q <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_push)
				rq_wr_q <= ~rq_wr_q;
			if (rq_pop)
				rq_rd_q <= ~rq_rd_q;
			case ({rq_push, rq_pop})
				2'b10: rq_cnt_q <= rq_cnt_q + 2'd1;
				2'b01: rq_cnt_q <= rq_cnt_q - 2'd1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	`DRI_ASSERT_IMPLY(a_rq_room, clk, arst_n, rq_push, rq_cnt_q != 2'd2, "result word pushed into full queue")
	`DRI_ASSERT_IMPLY(a_cor_done, clk, arst_n, cor_done, state_q == S_ROT, "rotator finished outside rotate step")
	`DRI_ASSERT_IMPLY(a_div_done, clk, arst_n, div_done, (state_q == S_GDIV) || (state_q == S_VDIV), "divider finished outside a divide step")

endmodule

FILE: hw/rtl/dead_reckoning_integrator.sv
// 2-d dead reckoning integrator, top level: configuration registers, front and back
// start and skipped words go straight to the result queue; integrated words run the full sequence
// the back sequencer takes a new word only when idle, one word at a time; an integrated word needs
//   16 cordic iterations plus two passes through the divide-by-one-million unit (one when still)
// reset: asynchronous active-low arst_n clears queues, sequencer and navigation state,
//   and loads the configuration registers with their defaults
module dead_reckoning_integrator import dri_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  sample_t     sample,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	// register map
	localparam logic [2:0] REG_PPM      = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
	localparam logic [2:0] REG_THRESH   = 3'd3;
	localparam logic [2:0] REG_DT_LIMIT = 3'd4;

	cfg_t cfg_q;
	logic op_valid;
	op_t  op;
	logic op_take;

	// config must be written only while idle (the block does not enforce this), so no shadowing is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixels_per_meter <= 16'd25600;
			cfg_q.origin_x <= 16'd512;
			cfg_q.origin_y <= 16'd512;
			cfg_q.accel_threshold <= 16'd64;
			cfg_q.dt_limit_us <= 20'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PPM:      cfg_q.pixels_per_meter <= cfg_data[15:0];
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data[15:0];
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data[15:0];
				REG_THRESH:   cfg_q.accel_threshold <= cfg_data[15:0];
				REG_DT_LIMIT: cfg_q.dt_limit_us <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: takes words, tracks the first sample, clamps time, two-entry op queue
	dri_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.cfg      (cfg_q),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	// back: rotation, stillness test, velocity and position update, pixel mapping
	dri_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
